/* rtl/core/hng_pkg.sv */
// ----------------------------------------------------------------------------
// hng_pkg
// Shared constants for the heightmap normal generator: register indexes,
// reset values and the packing of the result stream.
// ----------------------------------------------------------------------------
package hng_pkg;

	localparam int DEFAULT_MAX_WIDTH = 2048;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HEIGHT_SCALE = 2'd2;

	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd2048;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd2048;
	localparam logic [15:0] RST_HEIGHT_SCALE = 16'd4096;

	// result tdata layout, lowest bit up
	localparam int NX_LSB   = 0;
	localparam int NY_LSB   = 16;
	localparam int NZ_LSB   = 31;
	localparam int COL_LSB  = 47;
	localparam int ROW_LSB  = 58;
	localparam int OUT_BITS = 80;

endpackage

/* rtl/core/heightmap_normal_generator_core.sv */
// ----------------------------------------------------------------------------
// heightmap_normal_generator_core
// Central-difference unit normals of a raster-order 8-bit height image.
// ----------------------------------------------------------------------------
// One height sample is taken per transfer; the normal of pixel (r-1, c-1)
// leaves on the result stream after the sample at (r, c) arrives, border
// pixels give none. An item that yields no result passes only the memory
// read and write back; one that yields a result goes on through two
// multiply stages, the sum of squares, a 26-step bit-serial square root,
// the latch of the length and three passes of a 16-step restoring division
// on a shared divider, then loads the output register once it is free.
// The two line buffers are single memories with a registered read, indexed
// by the column. A finished result waits in the output register while the
// next sample is taken.
module heightmap_normal_generator_core #(
	parameter int MAX_WIDTH = hng_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_wdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // height_sample
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// normal_x[15:0], normal_y[30:16], normal_z[46:31], center_column[57:47],
	// center_row[73:58], zero pad[79:74]
	output logic [hng_pkg::OUT_BITS-1:0] m_tdata,
	output logic                         m_tlast    // frame_last
);
	import hng_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_SQR   = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_SQRT  = 3'd4;
	localparam logic [2:0] ST_DIVLD = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_OUT   = 3'd7;

	logic [2:0]    state_q;
	logic [11:0]   image_width_q;
	logic [15:0]   image_height_q;
	logic [15:0]   height_scale_q;
	logic [CW-1:0] column_q;
	logic [15:0]   row_q;
	logic [7:0]    recent0_q, recent1_q, left_q, up_delay_q;

	logic [7:0] row_above_mem [MAX_WIDTH];
	logic [7:0] two_above_mem [MAX_WIDTH];
	logic [7:0] above_s1, above2_s1;

	logic [CW-1:0] col_s1;
	logic [15:0]   row_s1;
	logic [7:0]    sample_s1;

	logic signed [24:0] a_q, b_q;
	logic [49:0]        a2_q, b2_q;
	logic [51:0]        v_q, res_q, bit_q;
	logic [25:0]        len_q;
	logic [4:0]         sqrt_cnt_q;
	logic [41:0]        rem_q, dsh_q;
	logic [15:0]        quo_q;
	logic [3:0]         div_cnt_q;
	logic [1:0]         comp_q;
	logic               neg_q;
	logic [15:0]        nx_q, nz_q;
	logic [14:0]        ny_q;
	logic [10:0]        cc_q;
	logic [15:0]        cr_q;
	logic               last_q;

	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic [CW-1:0] c_eff;
	logic [15:0]   r_eff;
	logic          accept;
	logic          out_load;

	always_comb begin
		if (32'(image_width_q) < 32'd3) begin
			w_eff = WW'(3);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		h_eff = (image_height_q < 16'd3) ? 16'd3 : image_height_q;
		c_eff = (32'(column_q) > 32'(w_eff) - 32'd1) ? CW'(32'(w_eff) - 32'd1) : column_q;
		r_eff = (row_q > h_eff - 16'd1) ? h_eff - 16'd1 : row_q;
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_OUT) && (comp_q == 2'd3) && (!m_tvalid || m_tready);

	// line buffers: read on the transfer, written back in the next cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			above_s1  <= row_above_mem[c_eff];
			above2_s1 <= two_above_mem[c_eff];
		end
		if (state_q == ST_READ) begin
			row_above_mem[col_s1] <= sample_s1;
			two_above_mem[col_s1] <= above_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			height_scale_q <= RST_HEIGHT_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[11:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				REG_HEIGHT_SCALE: height_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic        [52:0] trial;
	logic signed [8:0]  dx_diff, dz_diff;
	logic signed [25:0] a_full, b_full;
	logic        [23:0] a_abs, b_abs;
	logic        [47:0] a_sq, b_sq;
	logic        [23:0] mag;
	logic        [41:0] numer;

	always_comb begin
		trial   = {1'b0, res_q} + {1'b0, bit_q};
		dx_diff = $signed({1'b0, recent1_q}) - $signed({1'b0, above_s1});
		dz_diff = $signed({1'b0, up_delay_q}) - $signed({1'b0, left_q});
		a_full  = 26'(dx_diff) * 26'($signed({1'b0, height_scale_q}));
		b_full  = 26'(dz_diff) * 26'($signed({1'b0, height_scale_q}));
		a_abs   = a_q[24] ? 24'(-a_q) : a_q[23:0];
		b_abs   = b_q[24] ? 24'(-b_q) : b_q[23:0];
		a_sq    = 48'(a_abs) * 48'(a_abs);
		b_sq    = 48'(b_abs) * 48'(b_abs);
		unique case (comp_q)
			2'd0:    mag = a_abs;
			2'd1:    mag = 24'd4096;
			default: mag = b_abs;
		endcase
		numer = {3'd0, mag, 15'd0} + {16'd0, len_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			column_q   <= '0;
			row_q      <= '0;
			recent0_q  <= '0;
			recent1_q  <= '0;
			left_q     <= '0;
			up_delay_q <= '0;
			m_tvalid   <= 1'b0;
			sqrt_cnt_q <= '0;
			div_cnt_q  <= '0;
			comp_q     <= '0;
		end else begin
			if (out_load) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {6'd0, cr_q, cc_q, nz_q, ny_q, nx_q};
				m_tlast  <= last_q;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_s1    <= c_eff;
						row_s1    <= r_eff;
						sample_s1 <= s_tdata;
						if (32'(c_eff) + 32'd1 >= 32'(w_eff)) begin
							column_q <= '0;
							row_q <= (32'(r_eff) + 32'd1 >= 32'(h_eff)) ? 16'd0
								: r_eff + 16'd1;
						end else begin
							column_q <= c_eff + CW'(1);
							row_q    <= r_eff;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					recent1_q  <= recent0_q;
					recent0_q  <= above_s1;
					up_delay_q <= above2_s1;
					left_q     <= sample_s1;
					a_q <= a_full[24:0];
					b_q <= b_full[24:0];
					cc_q <= 11'(32'(col_s1) - 32'd1);
					cr_q <= row_s1 - 16'd1;
					last_q <= (32'(col_s1) - 32'd1 == 32'(w_eff) - 32'd2)
						&& (row_s1 - 16'd1 == h_eff - 16'd2);
					state_q <= (row_s1 >= 16'd2 && 32'(col_s1) >= 32'd2) ? ST_SQR : ST_IDLE;
				end
				ST_SQR: begin
					a2_q <= {2'd0, a_sq};
					b2_q <= {2'd0, b_sq};
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					v_q   <= {2'd0, a2_q} + {2'd0, b2_q} + 52'h1000000;
					res_q <= '0;
					bit_q <= 52'd1 << 50;
					sqrt_cnt_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if ({1'b0, v_q} >= trial) begin
						v_q   <= v_q - trial[51:0];
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					sqrt_cnt_q <= sqrt_cnt_q + 5'd1;
					if (sqrt_cnt_q == 5'd25) begin
						state_q <= ST_DIVLD;
						comp_q  <= 2'd3;
					end
				end
				ST_DIVLD: begin
					if (comp_q == 2'd3) begin
						// comp code 3 marks the cycle that latches the length
						len_q <= res_q[25:0];
						state_q <= ST_DIVLD;
						comp_q  <= 2'd0;
					end else begin
						rem_q <= numer;
						dsh_q <= {len_q, 16'd0};
						quo_q <= '0;
						neg_q <= (comp_q == 2'd0) ? a_q[24] : (comp_q == 2'd2) ? b_q[24] : 1'b0;
						div_cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						quo_q <= {quo_q[14:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					div_cnt_q <= div_cnt_q + 4'd1;
					if (div_cnt_q == 4'd15) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					unique case (comp_q)
						2'd0: begin
							nx_q <= neg_q ? -quo_q : quo_q;
							comp_q <= 2'd1;
							state_q <= ST_DIVLD;
						end
						2'd1: begin
							ny_q <= quo_q[14:0];
							comp_q <= 2'd2;
							state_q <= ST_DIVLD;
						end
						2'd2: begin
							nz_q <= neg_q ? -quo_q : quo_q;
							comp_q <= 2'd3;
							state_q <= ST_OUT;
						end
						default: begin
							// hold until the output register is free
							if (out_load) begin
								state_q <= ST_IDLE;
							end
						end
					endcase
				end
			endcase
		end
	end

endmodule

/* rtl/core/hng_checker.sv */
// ----------------------------------------------------------------------------
// hng_assertions
// Port-level checks of the heightmap normal generator result stream.
// ----------------------------------------------------------------------------
module hng_assertions (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [hng_pkg::OUT_BITS-1:0] m_tdata,
	input logic                         m_tlast
);
	import hng_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_ny_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[NZ_LSB-1:NY_LSB] != 15'd0)
		else $error("normal y component is zero");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[ROW_LSB-1:COL_LSB] != 11'd0
			&& m_tdata[ROW_LSB+15:ROW_LSB] != 16'd0)
		else $error("border pixel produced a result");

endmodule

bind heightmap_normal_generator_core hng_assertions u_hng_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

/* test/hng_checker.sv */
// ----------------------------------------------------------------------------
// hng_checker
// Watches the configuration port and both streams of the normal generator,
// predicts the normal of every interior pixel from the accepted height
// samples and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module hng_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [15:0]                  cfg_wdata,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [hng_pkg::OUT_BITS-1:0] m_tdata,
	input  logic                         m_tlast,
	output int                           mismatch_count,
	output int                           pending_normals,
	output int                           normals_seen
);
	import hng_pkg::*;

	typedef struct packed {
		logic [15:0] nx;
		logic [14:0] ny;
		logic [15:0] nz;
		logic [10:0] col;
		logic [15:0] row;
		logic        last;
	} normal_t;

	normal_t     normal_q[$];
	logic [11:0] width_reg;
	logic [15:0] height_reg;
	logic [15:0] scale_reg;
	int unsigned col_cnt;
	int unsigned row_cnt;
	logic [7:0]  line_above[DEFAULT_MAX_WIDTH];
	logic [7:0]  line_above2[DEFAULT_MAX_WIDTH];
	logic [7:0]  above_d1;
	logic [7:0]  above_d2;
	logic [7:0]  left_px;
	logic [7:0]  up_px;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// round half away from zero of v*16384/len
	function automatic longint unit_component(longint v, longint unsigned len);
		longint unsigned mag;
		longint unsigned q;
		mag = (v < 0) ? -v : v;
		q = (mag * 32768 + len) / (2 * len);
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	task automatic predict_sample(input logic [7:0] s);
		int unsigned     w;
		int unsigned     h;
		int unsigned     c;
		int unsigned     r;
		logic [7:0]      above;
		logic [7:0]      above2;
		longint          a;
		longint          b;
		longint unsigned len;
		normal_t         n;
		w = width_reg;
		h = height_reg;
		if (w < 3) w = 3;
		if (w > DEFAULT_MAX_WIDTH) w = DEFAULT_MAX_WIDTH;
		if (h < 3) h = 3;
		c = (col_cnt > w - 1) ? w - 1 : col_cnt;
		r = (row_cnt > h - 1) ? h - 1 : row_cnt;
		above = line_above[c];
		above2 = line_above2[c];
		if (r >= 2 && c >= 2) begin
			a = -(longint'(above) - longint'(above_d2)) * longint'(scale_reg);
			b = -(longint'(left_px) - longint'(up_px)) * longint'(scale_reg);
			len = int_sqrt(longint'(a * a) + longint'(b * b) + (64'd1 << 24));
			n.nx = 16'(unit_component(a, len));
			n.ny = 15'(unit_component(4096, len));
			n.nz = 16'(unit_component(b, len));
			n.col = 11'(c - 1);
			n.row = 16'(r - 1);
			n.last = (c - 1 == w - 2) && (r - 1 == h - 2);
			normal_q = {normal_q, n};
		end
		above_d2 = above_d1;
		above_d1 = above;
		up_px = above2;
		left_px = s;
		line_above2[c] = above;
		line_above[c] = s;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
			row_cnt = r;
		end
	endtask

	task automatic compare_normal();
		normal_t n;
		if (normal_q.size() == 0) begin
			$error("unexpected normal transfer: tdata %h tlast %b", m_tdata, m_tlast);
			mismatch_count++;
			return;
		end
		n = normal_q.pop_front();
		if (m_tdata[NX_LSB +: 16] !== n.nx) begin
			$error("normal_x: expected %0d, got %0d", $signed(n.nx),
				$signed(m_tdata[NX_LSB +: 16]));
			mismatch_count++;
		end
		if (m_tdata[NY_LSB +: 15] !== n.ny) begin
			$error("normal_y: expected %0d, got %0d", n.ny, m_tdata[NY_LSB +: 15]);
			mismatch_count++;
		end
		if (m_tdata[NZ_LSB +: 16] !== n.nz) begin
			$error("normal_z: expected %0d, got %0d", $signed(n.nz),
				$signed(m_tdata[NZ_LSB +: 16]));
			mismatch_count++;
		end
		if (m_tdata[COL_LSB +: 11] !== n.col) begin
			$error("center_column: expected %0d, got %0d", n.col, m_tdata[COL_LSB +: 11]);
			mismatch_count++;
		end
		if (m_tdata[ROW_LSB +: 16] !== n.row) begin
			$error("center_row: expected %0d, got %0d", n.row, m_tdata[ROW_LSB +: 16]);
			mismatch_count++;
		end
		if (m_tlast !== n.last) begin
			$error("frame_last: expected %0b, got %0b", n.last, m_tlast);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			scale_reg = RST_HEIGHT_SCALE;
			col_cnt = 0;
			row_cnt = 0;
			for (int i = 0; i < DEFAULT_MAX_WIDTH; i++) begin
				line_above[i] = 8'd0;
				line_above2[i] = 8'd0;
			end
			above_d1 = 8'd0;
			above_d2 = 8'd0;
			left_px = 8'd0;
			up_px = 8'd0;
			normal_q.delete();
			mismatch_count = 0;
			normals_seen = 0;
			pending_normals = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: width_reg = cfg_wdata[11:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_wdata;
					REG_HEIGHT_SCALE: scale_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_sample(s_tdata);
			if (m_tvalid && m_tready) begin
				compare_normal();
				normals_seen++;
			end
			pending_normals = normal_q.size();
		end
	end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Height image stimulus for the normal generator: directed corner frames,
// then random small frames under rotating valid/ready idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	import hng_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	localparam int MODE_RANDOM  = 0;
	localparam int MODE_EXTREME = 1;
	localparam int MODE_SMOOTH  = 2;
	localparam int MODE_FLAT    = 3;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [15:0]         cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;
	logic                m_tlast;
	int                  mismatch_count;
	int                  pending_normals;
	int                  normals_seen;
	int                  cycle_cnt = 0;
	int                  samples_sent;
	int                  frames_sent;
	int                  gap_pct;
	int                  stall_pct;
	logic [7:0]          last_px;

	heightmap_normal_generator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	hng_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.mismatch_count(mismatch_count), .pending_normals(pending_normals),
		.normals_seen(normals_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stalls follow the current idling phase
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	function automatic logic [7:0] next_sample(int mode);
		case (mode)
			MODE_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
			MODE_SMOOTH: return last_px + 8'($urandom_range(6)) - 8'd3;
			MODE_FLAT: return last_px;
			default: return 8'($urandom);
		endcase
	endfunction

	// rotate: none, sender gaps, receiver stalls, both
	task automatic pick_phase();
		case ((samples_sent / 150) % 4)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 51; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 51; end
			default: begin gap_pct = 11; stall_pct = 11; end
		endcase
	endtask

	task automatic send_sample(input logic [7:0] px);
		pick_phase();
		if ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		last_px = px;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
	endtask

	task automatic send_run(int n, int mode);
		for (int i = 0; i < n; i++)
			send_sample(next_sample(mode));
	endtask

	// drain results, then let a trailing no-result item finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_normals != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] w, logic [15:0] h, logic [15:0] sc);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_index <= REG_HEIGHT_SCALE;
		cfg_wdata <= sc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sizes below three are clamped, so send the frame the block will see
	task automatic run_frame(int w, int h, logic [15:0] sc, int mode);
		wait_idle();
		write_regs({4'($urandom), 12'(w)}, 16'(h), sc);
		send_run(((w < 3) ? 3 : w) * ((h < 3) ? 3 : h), mode);
		frames_sent++;
	endtask

	initial begin
		int w;
		int h;
		logic [15:0] sc;
		samples_sent = 0;
		frames_sent = 0;
		gap_pct = 0;
		stall_pct = 0;
		last_px = 8'd128;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = 16'd0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// steepest slopes at full scale, then zero scale and clamped sizes
		wait_idle();
		write_regs(16'd3, 16'd3, 16'hFFFF);
		send_sample(8'h00); send_sample(8'hFF); send_sample(8'h00);
		send_sample(8'hFF); send_sample(8'h80); send_sample(8'h00);
		send_sample(8'h00); send_sample(8'hFF); send_sample(8'hFF);
		run_frame(0, 0, 16'd0, MODE_EXTREME);
		run_frame(4, 4, 16'd4096, MODE_EXTREME);

		// tall image cut short: the row counter lands past the new last row
		wait_idle();
		write_regs(16'd3, 16'hFFFF, 16'd1);
		send_run(15, MODE_RANDOM);
		wait_idle();
		write_regs(16'd3, 16'd3, 16'h8000);
		send_run(3, MODE_RANDOM);

		// wide image, three rows
		run_frame(200, 3, 16'($urandom), MODE_RANDOM);

		while (samples_sent < 1850) begin
			w = $urandom_range(3, 9);
			h = $urandom_range(3, 6);
			case ($urandom_range(5))
				0: sc = 16'd0;
				1: sc = 16'hFFFF;
				2: sc = 16'($urandom_range(8192));
				default: sc = 16'($urandom);
			endcase
			run_frame(w, h, sc, $urandom_range(3));
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_normals != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d frames, %0d height samples and %0d normals,", frames_sent,
			samples_sent, normals_seen);
		$display("with size clamping, zero and full scale, and mixed stream idling.");
		if (mismatch_count == 0 && pending_normals == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/hng_pkg.sv
rtl/core/heightmap_normal_generator_core.sv
rtl/core/hng_checker.sv
test/hng_checker.sv
test/testbench.sv
